@@ sv/rbmc_pkg.sv @@
// Shared types and constants for the RSSI-by-MAC cache.
// No dependencies; imported by every module of the block.
`default_nettype none

package rbmc_pkg;

    localparam int ENTRIES = 48;
    localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W   = $clog2(ENTRIES + 1);

    localparam int MAC_W   = 48;
    localparam int RSSI_W  = 8;
    localparam int TIME_W  = 32;

    localparam logic [TIME_W-1:0] WINDOW_RESET = 32'd1200;

    localparam logic OP_RECORD = 1'b0;
    localparam logic OP_LOOKUP = 1'b1;

    localparam logic [MAC_W-1:0] MAC_NONE  = '0;
    localparam logic [MAC_W-1:0] MAC_BCAST = '1;

    typedef struct packed {
        logic                     op;
        logic [MAC_W-1:0]         mac;
        logic signed [RSSI_W-1:0] rssi;
        logic [TIME_W-1:0]        now;
    } t_req;

    typedef struct packed {
        logic [MAC_W-1:0]         mac;
        logic signed [RSSI_W-1:0] rssi;
        logic [TIME_W-1:0]        seen;
    } t_entry;

    // queue handshake toward the back end
    typedef struct packed {
        logic valid;
        t_req req;
    } t_queue_out;

endpackage : rbmc_pkg

`default_nettype wire

@@ sv/rssi_by_mac_cache_top.sv @@
// Top level of the RSSI-by-MAC cache: front end, queue and table back end.
// Depends on rbmc_pkg, rbmc_front and rbmc_back.
`default_nettype none

// A table of 48 sender MACs, each with its last RSSI and time stamp. A record
// refreshes the matching entry or overwrites the round-robin slot; records
// with zero RSSI or an all-zeros or all-ones MAC are dropped in the front end.
// A lookup always returns a result (found, RSSI); found marks a fresh match.
// The back end scans the table through its single read port, one entry per
// cycle. An item is loaded, the entries are read, the last read is compared,
// then the record is written or, once the output is free, the result registered.
// A two-entry queue lets new requests arrive while a scan is running.

module rssi_by_mac_cache_top
    import rbmc_pkg::*;
(
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_cfg_wr_en,
    input  wire logic [TIME_W-1:0]        i_cfg_wr_data,
    input  wire logic                     i_in_valid,
    output logic                          o_in_ready,
    input  wire logic                     i_opcode,
    input  wire logic [MAC_W-1:0]         i_mac_addr,
    input  wire logic signed [RSSI_W-1:0] i_rssi_sample,
    input  wire logic [TIME_W-1:0]        i_now_ms,
    output logic                          o_out_valid,
    input  wire logic                     i_out_ready,
    output logic                          o_found,
    output logic signed [RSSI_W-1:0]      o_rssi_out
);

    t_queue_out queue;
    logic       pop;

    rbmc_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_opcode      (i_opcode),
        .i_mac_addr    (i_mac_addr),
        .i_rssi_sample (i_rssi_sample),
        .i_now_ms      (i_now_ms),
        .o_queue       (queue),
        .i_pop         (pop)
    );

    rbmc_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_queue       (queue),
        .o_pop         (pop),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_found       (o_found),
        .o_rssi_out    (o_rssi_out)
    );

endmodule : rssi_by_mac_cache_top

`default_nettype wire

@@ sv/rbmc_front.sv @@
// Front end: accepts requests, drops records that cannot be cached, and
// queues the rest in a two-entry queue. Depends on rbmc_pkg.
`default_nettype none

module rbmc_front
    import rbmc_pkg::*;
(
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_in_valid,
    output logic                          o_in_ready,
    input  wire logic                     i_opcode,
    input  wire logic [MAC_W-1:0]         i_mac_addr,
    input  wire logic signed [RSSI_W-1:0] i_rssi_sample,
    input  wire logic [TIME_W-1:0]        i_now_ms,
    output t_queue_out                    o_queue,
    input  wire logic                     i_pop
);

    t_req       r_slot [2];
    logic       r_wr_ptr, n_wr_ptr;
    logic       r_rd_ptr, n_rd_ptr;
    logic [1:0] r_count, n_count;

    logic accept;
    logic drop;
    logic push;
    logic pop;
    t_req req;

    assign o_in_ready = (r_count != 2'd2);
    assign accept     = i_in_valid && o_in_ready;

    // a record with no signal or a reserved MAC never touches the table
    assign drop = (i_opcode == OP_RECORD) &&
                  ((i_rssi_sample == '0) || (i_mac_addr == MAC_NONE) ||
                   (i_mac_addr == MAC_BCAST));

    assign push = accept && !drop;
    assign pop  = i_pop && (r_count != 2'd0);

    always_comb begin
        req.op   = i_opcode;
        req.mac  = i_mac_addr;
        req.rssi = i_rssi_sample;
        req.now  = i_now_ms;
    end

    always_comb begin
        n_wr_ptr = push ? ~r_wr_ptr : r_wr_ptr;
        n_rd_ptr = pop ? ~r_rd_ptr : r_rd_ptr;
        n_count  = r_count + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_slot[r_wr_ptr] <= req;
        end
    end

    assign o_queue.valid = (r_count != 2'd0);
    assign o_queue.req   = r_slot[r_rd_ptr];

endmodule : rbmc_front

`default_nettype wire

@@ sv/rbmc_back.sv @@
// Back end: scans the entry table one slot a cycle, then refreshes or
// inserts a record, or registers a lookup result. Depends on rbmc_pkg.
`default_nettype none

module rbmc_back
    import rbmc_pkg::*;
(
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_cfg_wr_en,
    input  wire logic [TIME_W-1:0]        i_cfg_wr_data,
    input  wire t_queue_out               i_queue,
    output logic                          o_pop,
    output logic                          o_out_valid,
    input  wire logic                     i_out_ready,
    output logic                          o_found,
    output logic signed [RSSI_W-1:0]      o_rssi_out
);

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_SCAN   = 3'b010,
        S_FINISH = 3'b100
    } t_state;

    t_state r_state, n_state;

    t_entry mem [ENTRIES];
    logic [ENTRIES-1:0] r_vld;
    logic [IDX_W-1:0]   r_head;
    logic [TIME_W-1:0]  r_window;

    t_req              r_req;
    logic [CNT_W-1:0]  r_cnt;
    t_entry            r_rd;
    logic              r_rd_vld;
    logic              r_cmp_en;
    logic [IDX_W-1:0]  r_cmp_idx;

    logic                     r_found;
    logic [IDX_W-1:0]         r_idx;
    logic [TIME_W-1:0]        r_best;
    logic signed [RSSI_W-1:0] r_best_rssi;

    logic                     r_out_valid;
    logic                     r_out_found;
    logic signed [RSSI_W-1:0] r_out_rssi;

    logic             issue;
    logic [IDX_W-1:0] rd_addr;
    logic             mac_eq;
    logic [TIME_W:0]  diff;
    logic             fresh;
    logic             take_rec;
    logic             take_look;
    logic             out_free;
    logic             finish;
    logic             mem_we;
    logic [IDX_W-1:0] wr_addr;
    t_entry           wr_data;

    assign issue   = (r_state == S_SCAN) && (r_cnt < CNT_W'(ENTRIES));
    assign rd_addr = issue ? r_cnt[IDX_W-1:0] : '0;

    assign mac_eq = r_cmp_en && r_rd_vld && (r_rd.mac == r_req.mac);
    // time running backwards counts as age zero
    assign diff   = {1'b0, r_req.now} - {1'b0, r_rd.seen};
    assign fresh  = diff[TIME_W] || (diff[TIME_W-1:0] <= r_window);

    assign take_rec  = (r_req.op == OP_RECORD) && mac_eq && !r_found;
    assign take_look = (r_req.op == OP_LOOKUP) && mac_eq && (r_rd.rssi != '0) && fresh &&
                       (!r_found || (r_rd.seen >= r_best));

    assign out_free = !r_out_valid || i_out_ready;
    assign finish   = (r_state == S_FINISH) && ((r_req.op == OP_RECORD) || out_free);
    assign o_pop    = (r_state == S_IDLE) && i_queue.valid;

    assign mem_we  = finish && (r_req.op == OP_RECORD);
    assign wr_addr = r_found ? r_idx : r_head;
    always_comb begin
        wr_data.mac  = r_req.mac;
        wr_data.rssi = r_req.rssi;
        wr_data.seen = r_req.now;
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_queue.valid) n_state = S_SCAN;
            end
            S_SCAN: begin
                // last read is compared in this cycle
                if (r_cnt == CNT_W'(ENTRIES)) n_state = S_FINISH;
            end
            S_FINISH: begin
                if (finish) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_vld       <= '0;
            r_head      <= '0;
            r_window    <= WINDOW_RESET;
            r_cnt       <= '0;
            r_cmp_en    <= 1'b0;
            r_found     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cmp_en <= issue;
            if (i_cfg_wr_en) begin
                r_window <= i_cfg_wr_data;
            end
            if (o_pop) begin
                r_cnt   <= '0;
                r_found <= 1'b0;
            end else if (issue) begin
                r_cnt <= r_cnt + 1'b1;
            end
            if (take_rec || take_look) begin
                r_found <= 1'b1;
            end
            if (mem_we && !r_found) begin
                r_vld[r_head] <= 1'b1;
                r_head <= (r_head == IDX_W'(ENTRIES - 1)) ? '0 : r_head + 1'b1;
            end
            if (finish && (r_req.op == OP_LOOKUP)) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_req <= i_queue.req;
        end
        if (take_rec) begin
            r_idx <= r_cmp_idx;
        end
        if (take_look) begin
            r_best      <= r_rd.seen;
            r_best_rssi <= r_rd.rssi;
        end
        if (finish && (r_req.op == OP_LOOKUP)) begin
            r_out_found <= r_found;
            r_out_rssi  <= r_found ? r_best_rssi : '0;
        end
        r_rd_vld  <= r_vld[rd_addr];
        r_cmp_idx <= rd_addr;
    end

    // entry table: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[wr_addr] <= wr_data;
        end
        r_rd <= mem[rd_addr];
    end

    assign o_out_valid = r_out_valid;
    assign o_found     = r_out_found;
    assign o_rssi_out  = r_out_rssi;

    a_head_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_head <= IDX_W'(ENTRIES - 1))
        else $error("insert head out of range");

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(ENTRIES))
        else $error("scan counter out of range");

    a_result_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_FINISH && r_req.op == OP_LOOKUP))
        else $error("result without a finished lookup");

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_found) |-> (r_out_rssi == '0))
        else $error("miss carries nonzero RSSI");

endmodule : rbmc_back

`default_nettype wire

@@ bench/rssi_by_mac_cache_top_test.sv @@
// Testbench for rssi_by_mac_cache_top: directed and random record and lookup requests,
// with every lookup result checked against a behavioral copy of the MAC table.
// Depends on rbmc_pkg and the RTL of the block; needs no other files.
module rssi_by_mac_cache_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    import rbmc_pkg::*;

    localparam int POOL_SIZE      = 56;
    localparam int DRAIN_CYCLES   = 200;
    localparam int HOLDOFF_CYCLES = 1000;
    localparam int END_WAIT_LIMIT = 50000;
    localparam int MAX_REPORTS    = 40;
    localparam int RUN_LIMIT_NS   = 3000000;

    typedef struct packed {
        logic                     found;
        logic signed [RSSI_W-1:0] rssi;
    } t_lookup_result;

    logic                     i_clk         = 1'b0;
    logic                     i_rst_n       = 1'b0;
    logic                     i_cfg_wr_en   = 1'b0;
    logic [TIME_W-1:0]        i_cfg_wr_data = '0;
    logic                     i_in_valid    = 1'b0;
    logic                     o_in_ready;
    logic                     i_opcode      = OP_RECORD;
    logic [MAC_W-1:0]         i_mac_addr    = '0;
    logic signed [RSSI_W-1:0] i_rssi_sample = '0;
    logic [TIME_W-1:0]        i_now_ms      = '0;
    logic                     o_out_valid;
    logic                     i_out_ready   = 1'b0;
    logic                     o_found;
    logic signed [RSSI_W-1:0] o_rssi_out;

    rssi_by_mac_cache_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_opcode      (i_opcode),
        .i_mac_addr    (i_mac_addr),
        .i_rssi_sample (i_rssi_sample),
        .i_now_ms      (i_now_ms),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_found       (o_found),
        .o_rssi_out    (o_rssi_out)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Behavioral copy of the MAC table
    logic                     tbl_valid [ENTRIES];
    logic [MAC_W-1:0]         tbl_mac   [ENTRIES];
    logic signed [RSSI_W-1:0] tbl_rssi  [ENTRIES];
    logic [TIME_W-1:0]        tbl_seen  [ENTRIES];
    int unsigned              tbl_head  = 0;
    logic [TIME_W-1:0]        window_ms = WINDOW_RESET;

    t_lookup_result lookup_answers[$];

    int unsigned mismatch_count = 0;

    int unsigned idle_pct            = 0;
    int unsigned stall_pct           = 0;
    int unsigned holdoff_req_seq     = 0;
    int unsigned holdoff_ack_seq     = 0;
    int unsigned holdoff_cycles_left = 0;

    logic [MAC_W-1:0]  mac_pool [POOL_SIZE];
    logic [TIME_W-1:0] clock_ms = '0;

    initial begin
        for (int i = 0; i < ENTRIES; i++) begin
            tbl_valid[i] = 1'b0;
        end
    end

    function automatic void table_record(input logic [MAC_W-1:0] mac,
                                         input logic signed [RSSI_W-1:0] rssi,
                                         input logic [TIME_W-1:0] now);
        int slot;
        slot = -1;
        if (rssi == 0 || mac == MAC_NONE || mac == MAC_BCAST)
            return;
        for (int i = 0; i < ENTRIES; i++) begin
            if (slot < 0 && tbl_valid[i] && tbl_mac[i] == mac)
                slot = i;
        end
        // no live entry for this MAC: overwrite the round-robin slot
        if (slot < 0) begin
            slot = tbl_head;
            tbl_head = (tbl_head + 1) % ENTRIES;
            tbl_mac[slot] = mac;
            tbl_valid[slot] = 1'b1;
        end
        tbl_rssi[slot] = rssi;
        tbl_seen[slot] = now;
    endfunction

    function automatic t_lookup_result table_lookup(input logic [MAC_W-1:0] mac,
                                                    input logic [TIME_W-1:0] now);
        t_lookup_result res;
        logic [TIME_W-1:0] age;
        logic [TIME_W-1:0] best;
        res.found = 1'b0;
        res.rssi = '0;
        best = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            if (tbl_valid[i] && tbl_rssi[i] != 0 && tbl_mac[i] == mac) begin
                // a stamp from the future counts as age zero
                age = (now >= tbl_seen[i]) ? now - tbl_seen[i] : '0;
                if (age <= window_ms && (!res.found || tbl_seen[i] >= best)) begin
                    res.found = 1'b1;
                    best = tbl_seen[i];
                    res.rssi = tbl_rssi[i];
                end
            end
        end
        return res;
    endfunction

    task automatic report_mismatch(input string msg);
        if (mismatch_count < MAX_REPORTS)
            $display("[%0t] mismatch: %s", $realtime, msg);
        mismatch_count++;
    endtask

    // Update the table copy for every request the block accepts
    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && o_in_ready) begin
            if (i_opcode == OP_RECORD)
                table_record(i_mac_addr, i_rssi_sample, i_now_ms);
            else
                lookup_answers.insert(lookup_answers.size(),
                                      table_lookup(i_mac_addr, i_now_ms));
        end
    end

    always @(posedge i_clk) begin : check_results
        t_lookup_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (lookup_answers.size() == 0) begin
                report_mismatch($sformatf("unexpected result found=%0d rssi=%0d",
                                          o_found, o_rssi_out));
            end else begin
                want = lookup_answers.pop_front();
                if (o_found !== want.found)
                    report_mismatch($sformatf("found %0d, want %0d", o_found, want.found));
                if (o_rssi_out !== want.rssi)
                    report_mismatch($sformatf("rssi %0d, want %0d", o_rssi_out, want.rssi));
            end
        end
    end

    // Result side: random stalls, plus a long hold-off on request
    always @(posedge i_clk) begin
        if (holdoff_req_seq != holdoff_ack_seq) begin
            holdoff_ack_seq <= holdoff_req_seq;
            holdoff_cycles_left <= HOLDOFF_CYCLES;
            i_out_ready <= 1'b0;
        end else if (holdoff_cycles_left != 0) begin
            holdoff_cycles_left <= holdoff_cycles_left - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Must be called at a rising edge; returns at the edge that accepts the request.
    task automatic send_req(input logic op, input logic [MAC_W-1:0] mac,
                            input logic signed [RSSI_W-1:0] rssi,
                            input logic [TIME_W-1:0] now);
        while ($urandom_range(99) < idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_opcode      <= op;
        i_mac_addr    <= mac;
        i_rssi_sample <= rssi;
        i_now_ms      <= now;
        @(posedge i_clk);
        while (!o_in_ready)
            @(posedge i_clk);
    endtask

    // Drop valid, wait for all lookups to return, then let trailing records finish.
    task automatic settle_block();
        i_in_valid <= 1'b0;
        do
            @(posedge i_clk);
        while (lookup_answers.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_match_window(input logic [TIME_W-1:0] value);
        settle_block();
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        window_ms = value;
    endtask

    function automatic logic [MAC_W-1:0] random_mac();
        logic [63:0] w;
        w = {$urandom, $urandom};
        return w[MAC_W-1:0];
    endfunction

    function automatic logic [TIME_W-1:0] advance_clock(input logic [TIME_W-1:0] t);
        int unsigned p;
        p = $urandom_range(99);
        if (p < 70)
            return t + $urandom_range(40);
        if (p < 95)
            return t + $urandom_range(1500);
        if (p < 98)
            return t - $urandom_range(2000);
        return $urandom;
    endfunction

    task automatic fill_mac_pool();
        for (int i = 0; i < POOL_SIZE; i++)
            mac_pool[i] = random_mac();
    endtask

    task automatic test_dropped_records();
        send_req(OP_RECORD, MAC_NONE, -8'sd50, 32'd100);
        send_req(OP_RECORD, MAC_BCAST, -8'sd50, 32'd100);
        send_req(OP_RECORD, 48'h02_00_00_00_00_01, 8'sd0, 32'd100);
        send_req(OP_LOOKUP, MAC_NONE, 8'sd0, 32'd100);
        send_req(OP_LOOKUP, MAC_BCAST, 8'sd0, 32'd100);
        send_req(OP_LOOKUP, 48'h02_00_00_00_00_01, 8'sd0, 32'd100);
    endtask

    task automatic test_rssi_extremes_and_age();
        send_req(OP_RECORD, 48'h00_00_00_00_00_01, -8'sd128, 32'd1000);
        send_req(OP_LOOKUP, 48'h00_00_00_00_00_01, 8'sd77, 32'd2200);
        send_req(OP_LOOKUP, 48'h00_00_00_00_00_01, -8'sd1, 32'd2201);
        // stamp near the top of the range, then look up after the wrap
        send_req(OP_RECORD, 48'hFF_FF_FF_FF_FF_FE, 8'sd127, 32'hFFFF_FFF0);
        send_req(OP_LOOKUP, 48'hFF_FF_FF_FF_FF_FE, 8'sd0, 32'h0000_0005);
    endtask

    task automatic test_refresh();
        send_req(OP_RECORD, 48'hA5_5A_C3_3C_0F_F0, -8'sd40, 32'd5000);
        send_req(OP_RECORD, 48'hA5_5A_C3_3C_0F_F0, -8'sd1, 32'd5100);
        send_req(OP_LOOKUP, 48'hA5_5A_C3_3C_0F_F0, 8'sd0, 32'd5200);
        send_req(OP_LOOKUP, 48'hA5_5A_C3_3C_0F_F1, 8'sd0, 32'd5200);
    endtask

    task automatic test_zero_window();
        set_match_window('0);
        send_req(OP_RECORD, 48'h5A_A5_3C_C3_F0_0F, 8'sd1, 32'd7000);
        send_req(OP_LOOKUP, 48'h5A_A5_3C_C3_F0_0F, 8'sd0, 32'd7000);
        send_req(OP_LOOKUP, 48'h5A_A5_3C_C3_F0_0F, 8'sd0, 32'd7001);
    endtask

    task automatic test_full_window();
        set_match_window('1);
        send_req(OP_LOOKUP, 48'h5A_A5_3C_C3_F0_0F, 8'sd0, 32'hFFFF_FFFF);
        send_req(OP_LOOKUP, 48'h00_00_00_00_00_01, 8'sd0, 32'h8000_0000);
    endtask

    task automatic test_input_backpressure();
        idle_pct = 0;
        stall_pct <= 0;
        fill_mac_pool();
        clock_ms = $urandom;
        // hold off the result side so the block backs up into its input
        holdoff_req_seq <= holdoff_req_seq + 1;
        for (int i = 0; i < 6; i++)
            send_req(OP_RECORD, mac_pool[i], 8'($urandom_range(1, 255)), clock_ms + i);
        for (int i = 0; i < 6; i++)
            send_req(OP_LOOKUP, mac_pool[i], 8'($urandom), clock_ms + 10);
        settle_block();
    endtask

    task automatic test_random_traffic(input int unsigned n_items, input int unsigned idle,
                                       input int unsigned stall);
        int unsigned pick;
        logic [MAC_W-1:0] mac;
        logic signed [RSSI_W-1:0] rssi;
        logic op;
        idle_pct = idle;
        stall_pct <= stall;
        fill_mac_pool();
        clock_ms = $urandom;
        for (int unsigned k = 0; k < n_items; k++) begin
            pick = $urandom_range(99);
            clock_ms = advance_clock(clock_ms);
            mac = mac_pool[$urandom_range(POOL_SIZE - 1)];
            rssi = 8'($urandom);
            op = $urandom_range(1) ? OP_LOOKUP : OP_RECORD;
            if (pick < 45)
                send_req(OP_RECORD, mac, rssi, clock_ms);
            else if (pick < 88)
                send_req(OP_LOOKUP, mac, rssi, clock_ms);
            else if (pick < 92)
                send_req(op, mac ^ (48'd1 << $urandom_range(MAC_W - 1)), rssi, clock_ms);
            else if (pick < 94)
                send_req(OP_RECORD, mac, 8'sd0, clock_ms);
            else if (pick < 96)
                send_req(op, MAC_NONE, rssi, clock_ms);
            else if (pick < 98)
                send_req(op, MAC_BCAST, rssi, clock_ms);
            else
                send_req(op, random_mac(), rssi, $urandom);
        end
        settle_block();
    endtask

    initial begin
        int unsigned spins;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_dropped_records();
        test_rssi_extremes_and_age();
        test_refresh();
        test_zero_window();
        test_full_window();
        test_input_backpressure();

        set_match_window(WINDOW_RESET);
        test_random_traffic(490, 0, 0);
        set_match_window(32'd60);
        test_random_traffic(490, 61, 0);
        set_match_window('1);
        test_random_traffic(490, 0, 61);
        set_match_window($urandom_range(3000));
        test_random_traffic(490, 8, 8);

        i_in_valid <= 1'b0;
        spins = 0;
        do begin
            @(posedge i_clk);
            spins++;
        end while (lookup_answers.size() != 0 && spins < END_WAIT_LIMIT);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (lookup_answers.size() != 0)
            report_mismatch($sformatf("%0d lookups never answered", lookup_answers.size()));

        if (mismatch_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    initial begin
        #(RUN_LIMIT_NS);
        $display("timeout");
        $display("== FAIL ==");
        $finish;
    end

endmodule
